/* rtl/tw_pkg.sv */
// Shared types, constants and helper functions for the two-walker grid collector.
package tw_pkg;

  localparam int MAX_COLS   = 64;
  localparam int CELL_BITS  = 8;
  localparam int SCORE_BITS = 20;
  localparam int CFG_W      = 7;

  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int CNT_W      = $clog2(MAX_COLS + 1);
  localparam int CMP_W      = (CFG_W > CNT_W) ? CFG_W : CNT_W;
  localparam int PAIR_DEPTH = 2 * MAX_COLS * MAX_COLS;
  localparam int ENT_W      = SCORE_BITS + 1;
  localparam int STEP_W     = 4;

  localparam logic [STEP_W-1:0] PRED_CNT  = STEP_W'(9);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(10);
  localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_MIDROW = 2'd1,
    STAT_SAT    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_EMIT
  } top_state_t;

  typedef enum logic {
    SW_IDLE,
    SW_RUN
  } sw_state_t;

  typedef struct packed {
    logic [CELL_BITS-1:0] cell_value;
    logic                 last_of_grid;
  } in_item_t;

  typedef struct packed {
    logic [SCORE_BITS-1:0] best_total;
    logic [1:0]            status;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic             first;
    logic             bank;
    logic [CNT_W-1:0] cols;
  } sweep_cmd_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [SCORE_BITS-1:0] best;
  } sweep_stat_t;

  // Saturating add at the score ceiling.
  function automatic logic [SCORE_BITS-1:0] sat_add(input logic [SCORE_BITS-1:0] x,
                                                    input logic [SCORE_BITS-1:0] y);
    logic [SCORE_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[SCORE_BITS] ? SCORE_MAX : s[SCORE_BITS-1:0];
  endfunction

  // Predecessor offsets (plus one) for step k: {row-walker offset, other offset}.
  function automatic logic [3:0] pred_off(input logic [STEP_W-1:0] k);
    logic [3:0] r;
    unique case (k)
      4'd0:    r = {2'd0, 2'd0};
      4'd1:    r = {2'd0, 2'd1};
      4'd2:    r = {2'd0, 2'd2};
      4'd3:    r = {2'd1, 2'd0};
      4'd4:    r = {2'd1, 2'd1};
      4'd5:    r = {2'd1, 2'd2};
      4'd6:    r = {2'd2, 2'd0};
      4'd7:    r = {2'd2, 2'd1};
      4'd8:    r = {2'd2, 2'd2};
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/tw_ram.sv */
// Generic simple dual-port RAM with registered read data.
module tw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tw_sweep.sv */
// Row sweep sequencer: rebuilds the pair table one entry at a time with a shared compare/add.
module tw_sweep import tw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sweep_cmd_t           cmd,
  output sweep_stat_t          stat,
  output logic [COL_W-1:0]     rb_raddr,
  input  logic [CELL_BITS-1:0] rb_rdata
);

  sw_state_t             state_r, state_nxt;
  logic [COL_W-1:0]      a_r, a_nxt, b_r, b_nxt;
  logic [STEP_W-1:0]     k_r, k_nxt;
  logic                  first_r, first_nxt, bank_r, bank_nxt;
  logic [CNT_W-1:0]      cols_r, cols_nxt;
  logic                  ok_r, ok_nxt, found_r, found_nxt, done_r, done_nxt;
  logic [SCORE_BITS-1:0] best_r, best_nxt, rba_r, rba_nxt, gain_r, gain_nxt;
  logic [SCORE_BITS-1:0] fmax_r, fmax_nxt;

  logic [CNT_W-1:0]      last_w, pa_w, pb_w, pa_i, pb_i;
  logic [COL_W-1:0]      lastcol;
  logic [3:0]            off;
  logic                  rd_ok, we;
  logic [2*COL_W:0]      raddr, waddr;
  logic [ENT_W-1:0]      rdata, wdata;
  logic                  ent_reach;
  logic [SCORE_BITS-1:0] ent_score;

  assign last_w  = cols_r - CNT_W'(1);
  assign lastcol = last_w[COL_W-1:0];
  assign off     = pred_off(k_r);
  assign pa_w    = CNT_W'(a_r) + CNT_W'(off[3:2]);
  assign pb_w    = CNT_W'(b_r) + CNT_W'(off[1:0]);
  assign pa_i    = pa_w - CNT_W'(1);
  assign pb_i    = pb_w - CNT_W'(1);
  assign rd_ok   = (state_r == SW_RUN) && !first_r && (k_r < PRED_CNT) &&
                   (pa_w != '0) && (pa_w <= cols_r) && (pb_w != '0) && (pb_w <= cols_r);
  assign raddr   = {bank_r, pa_i[COL_W-1:0], pb_i[COL_W-1:0]};
  assign waddr   = {~bank_r, a_r, b_r};
  assign we      = (state_r == SW_RUN) && (k_r == STEP_LAST);

  always_comb begin
    if (first_r) begin
      ent_reach = (a_r == '0) && (b_r == lastcol);
      ent_score = ent_reach ? gain_r : '0;
    end else begin
      ent_reach = found_r;
      ent_score = found_r ? sat_add(best_r, gain_r) : '0;
    end
  end
  assign wdata = {ent_reach, ent_score};

  tw_ram #(.WIDTH(ENT_W), .DEPTH(PAIR_DEPTH)) u_pair_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SW_IDLE: if (cmd.start) begin
        state_nxt = SW_RUN;
      end
      SW_RUN: if (we && (a_r == lastcol) && (b_r == lastcol)) begin
        state_nxt = SW_IDLE;
      end
      default: state_nxt = SW_IDLE;
    endcase
  end

  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    k_nxt     = k_r;
    first_nxt = first_r;
    bank_nxt  = bank_r;
    cols_nxt  = cols_r;
    found_nxt = found_r;
    best_nxt  = best_r;
    rba_nxt   = rba_r;
    gain_nxt  = gain_r;
    fmax_nxt  = fmax_r;
    ok_nxt    = rd_ok;
    done_nxt  = 1'b0;
    rb_raddr  = (k_r == '0) ? a_r : b_r;
    unique case (state_r)
      SW_IDLE: if (cmd.start) begin
        a_nxt     = '0;
        b_nxt     = '0;
        k_nxt     = '0;
        first_nxt = cmd.first;
        bank_nxt  = cmd.bank;
        cols_nxt  = cmd.cols;
        fmax_nxt  = '0;
      end
      SW_RUN: begin
        k_nxt = k_r + STEP_W'(1);
        if (k_r == STEP_W'(1)) begin
          rba_nxt = SCORE_BITS'(rb_rdata);
        end
        if (k_r == STEP_W'(2)) begin
          gain_nxt = (a_r == b_r) ? rba_r : sat_add(rba_r, SCORE_BITS'(rb_rdata));
        end
        if (ok_r && rdata[SCORE_BITS] &&
            (!found_r || (rdata[SCORE_BITS-1:0] > best_r))) begin
          best_nxt  = rdata[SCORE_BITS-1:0];
          found_nxt = 1'b1;
        end
        if (k_r == '0) begin
          found_nxt = 1'b0;
        end
        if (we) begin
          k_nxt = '0;
          if (ent_reach && (ent_score > fmax_r)) begin
            fmax_nxt = ent_score;
          end
          if (b_r == lastcol) begin
            b_nxt = '0;
            a_nxt = a_r + COL_W'(1);
            done_nxt = (a_r == lastcol);
          end else begin
            b_nxt = b_r + COL_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SW_IDLE;
      ok_r    <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ok_r    <= ok_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    k_r     <= k_nxt;
    first_r <= first_nxt;
    bank_r  <= bank_nxt;
    cols_r  <= cols_nxt;
    found_r <= found_nxt;
    best_r  <= best_nxt;
    rba_r   <= rba_nxt;
    gain_r  <= gain_nxt;
    fmax_r  <= fmax_nxt;
  end

  assign stat.busy = (state_r != SW_IDLE);
  assign stat.done = done_r;
  assign stat.best = fmax_r;

endmodule

/* rtl/two_walker_grid_max_collect.sv */
// Top level of the two-walker grid collector: input channel, row buffer, sequencing, result.
// A cell inside a row leaves ready high, so such cells run back to back unless one ends the grid.
// A cell that completes a row starts a sweep that rebuilds the pair table for every walker pair in
// turn, its pace set by the single read port of the pair table; ready is low meanwhile.
// After the final sweep or a mid-row end, the result waits in res_r and moves to the output register
// once it frees. Synchronous active-low reset clears the control state only.
module two_walker_grid_max_collect import tw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  // Control registers. The column counter, first-row flag and bank select mirror the
  // grid position; the pending result waits in res_r until the output register frees.
  top_state_t       state_r, state_nxt;
  logic [CFG_W-1:0] cfg_r;
  logic [CNT_W-1:0] col_cnt_r, col_cnt_nxt;
  logic             first_r, first_nxt, bank_r, bank_nxt;
  logic             last_pend_r, last_pend_nxt;
  out_item_t        res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic [CMP_W-1:0]     cfg_w;
  logic [CNT_W-1:0]     cols_act, cc, cc1;
  logic                 accept, row_end, out_free;
  logic [COL_W-1:0]     rb_raddr;
  logic [CELL_BITS-1:0] rb_rdata;
  sweep_cmd_t           sw_cmd;
  sweep_stat_t          sw_stat;

  // The column register is clamped into the legal range whenever it is used.
  assign cfg_w = CMP_W'(cfg_r);
  always_comb begin
    if (cfg_w < CMP_W'(2)) begin
      cols_act = CNT_W'(2);
    end else if (cfg_w > CMP_W'(MAX_COLS)) begin
      cols_act = CNT_W'(MAX_COLS);
    end else begin
      cols_act = CNT_W'(cfg_w);
    end
  end

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cfg_r <= cfg_data;
    end
  end

  // A cell is taken only while no sweep runs and no result waits to enter the output register.
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign cc       = (col_cnt_r >= cols_act) ? '0 : col_cnt_r;
  assign cc1      = cc + CNT_W'(1);
  assign row_end  = (cc1 >= cols_act);
  assign out_free = !out_valid_r || out_ready;

  tw_ram #(.WIDTH(CELL_BITS), .DEPTH(MAX_COLS)) u_row_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (cc[COL_W-1:0]),
    .wdata (in_data.cell_value),
    .raddr (rb_raddr),
    .rdata (rb_rdata)
  );

  assign sw_cmd.start = accept && row_end;
  assign sw_cmd.first = first_r;
  assign sw_cmd.bank  = bank_r;
  assign sw_cmd.cols  = cols_act;

  tw_sweep u_sweep (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (sw_cmd),
    .stat     (sw_stat),
    .rb_raddr (rb_raddr),
    .rb_rdata (rb_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) begin
        if (row_end) begin
          state_nxt = ST_SWEEP;
        end else if (in_data.last_of_grid) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SWEEP: if (sw_stat.done) begin
        state_nxt = last_pend_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: if (out_free) begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    col_cnt_nxt   = col_cnt_r;
    first_nxt     = first_r;
    bank_nxt      = bank_r;
    last_pend_nxt = last_pend_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: if (accept) begin
        last_pend_nxt = in_data.last_of_grid;
        if (row_end) begin
          col_cnt_nxt = '0;
        end else if (in_data.last_of_grid) begin
          // Grid ended part way through a row.
          col_cnt_nxt        = '0;
          first_nxt          = 1'b1;
          res_nxt.best_total = '0;
          res_nxt.status     = STAT_MIDROW;
        end else begin
          col_cnt_nxt = cc1;
        end
      end
      ST_SWEEP: if (sw_stat.done) begin
        bank_nxt           = ~bank_r;
        first_nxt          = last_pend_r;
        res_nxt.best_total = sw_stat.best;
        res_nxt.status     = (sw_stat.best == SCORE_MAX) ? STAT_SAT : STAT_OK;
      end
      ST_EMIT: if (out_free) begin
        out_data_nxt  = res_r;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_cnt_r   <= '0;
      first_r     <= 1'b1;
      bank_r      <= 1'b0;
      last_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_cnt_r   <= col_cnt_nxt;
      first_r     <= first_nxt;
      bank_r      <= bank_nxt;
      last_pend_r <= last_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The sweep must never overlap with taking a new cell.
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    sw_stat.busy |-> !in_ready)
    else $error("cell accepted during a sweep");

  // A sweep finishes only while the top level waits for it.
  a_done_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    sw_stat.done |-> (state_r == ST_SWEEP))
    else $error("sweep completion outside sweep state");

  // A mid-row result always carries a zero total.
  a_midrow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == STAT_MIDROW)) |-> (out_data_r.best_total == '0))
    else $error("mid-row result with nonzero total");

endmodule
